>>> sv/mfg_pkg.sv
`default_nettype none

package mfg_pkg;

  // frame size limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // field widths
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;

  // counter widths: input rows run past the frame while draining
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned OROW_W = $clog2(MAX_HEIGHT);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // input word kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // one line memory word: pixel one row up and two rows up
  typedef struct packed {
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] top;
  } lb_word_t;

  // per-word control carried down the pipeline
  typedef struct packed {
    logic emit;
    logic border;
    logic last;
    logic use_new;
  } item_ctl_t;

endpackage

`default_nettype wire

>>> sv/mfg_ctrl.sv
`default_nettype none

module mfg_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mfg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mfg_pkg::DIM_W-1:0]      cfg_data_i,
  input  logic                           accept_i,
  input  logic                           kind_i,
  output logic                           take_o,
  output logic [mfg_pkg::COL_W-1:0]      col_o,
  output mfg_pkg::item_ctl_t             ctl_o
);
  import mfg_pkg::*;

  localparam int unsigned POS_W = ((COL_W > DIM_W) ? COL_W : DIM_W) + 2;
  localparam logic [DIM_W-1:0] WID_RST = DIM_W'(320);
  localparam logic [DIM_W-1:0] HGT_RST = DIM_W'(240);

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input int unsigned lim);
    if (v == '0) return DIM_W'(1);
    if (32'(v) > lim) return DIM_W'(lim);
    return v;
  endfunction

  logic [DIM_W-1:0]  wid_q, hgt_q;
  logic [COL_W-1:0]  col_q, col_d, ocol_q, ocol_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [OROW_W-1:0] orow_q, orow_d;
  logic              row_full, active, emit, in_wrap, out_wrap, out_bot, last;

  always_comb begin
    row_full = POS_W'(row_q) >= POS_W'(hgt_q);
    active   = (kind_i == KIND_DRAIN) ? row_full : !row_full;
    // an output is due once the input is one row and one pixel ahead
    emit     = (kind_i == KIND_DRAIN) || (row_q >= ROW_W'(2)) ||
               ((row_q == ROW_W'(1)) && (col_q != '0));
    in_wrap  = POS_W'(col_q) + POS_W'(1) >= POS_W'(wid_q);
    out_wrap = POS_W'(ocol_q) + POS_W'(1) >= POS_W'(wid_q);
    out_bot  = POS_W'(orow_q) + POS_W'(1) >= POS_W'(hgt_q);
    last     = out_wrap && out_bot;

    ctl_o.emit    = emit;
    ctl_o.last    = last;
    ctl_o.border  = (orow_q == '0) || out_bot || (ocol_q == '0) || out_wrap;
    ctl_o.use_new = (hgt_q == DIM_W'(1));

    take_o = accept_i && active;
    col_o  = col_q;

    col_d  = col_q;
    row_d  = row_q;
    ocol_d = ocol_q;
    orow_d = orow_q;
    if (take_o) begin
      if (emit && last) begin
        col_d  = '0;
        row_d  = '0;
        ocol_d = '0;
        orow_d = '0;
      end else begin
        if (in_wrap) begin
          col_d = '0;
          row_d = row_q + ROW_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
        if (emit) begin
          if (out_wrap) begin
            ocol_d = '0;
            orow_d = orow_q + OROW_W'(1);
          end else begin
            ocol_d = ocol_q + COL_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q  <= WID_RST;
      hgt_q  <= HGT_RST;
      col_q  <= '0;
      row_q  <= '0;
      ocol_q <= '0;
      orow_q <= '0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      ocol_q <= ocol_d;
      orow_q <= orow_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WIDTH:  wid_q <= clamp_dim(cfg_data_i, MAX_WIDTH);
          REG_HEIGHT: hgt_q <= clamp_dim(cfg_data_i, MAX_HEIGHT);
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/mfg_line_buf.sv
`default_nettype none

module mfg_line_buf (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [mfg_pkg::COL_W-1:0] rd_addr_i,
  input  logic                      wr_en_i,
  input  logic [mfg_pkg::COL_W-1:0] wr_addr_i,
  input  mfg_pkg::lb_word_t         wr_data_i,
  output mfg_pkg::lb_word_t         rd_data_o
);
  import mfg_pkg::*;

  lb_word_t mem [MAX_WIDTH];
  lb_word_t rd_q;

  // same-column write in flight (one-pixel rows) is forwarded
  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem[wr_addr_i] <= wr_data_i;
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) rd_q <= wr_data_i;
      else rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

>>> sv/mfg_window.sv
`default_nettype none

module mfg_window (
  input  logic                      clk_i,
  input  logic                      shift_i,
  input  logic [mfg_pkg::PIX_W-1:0] top_i,
  input  logic [mfg_pkg::PIX_W-1:0] mid_i,
  input  logic [mfg_pkg::PIX_W-1:0] bot_i,
  input  logic                      border_i,
  input  logic                      use_new_i,
  output logic [mfg_pkg::PIX_W-1:0] pix_o
);
  import mfg_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } col_t;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a, b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a, b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a, b, c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic col_t sort3(input logic [PIX_W-1:0] a, b, c);
    col_t r;
    r.lo = min2(min2(a, b), c);
    r.md = med3(a, b, c);
    r.hi = max2(max2(a, b), c);
    return r;
  endfunction

  col_t             win_q [3];
  logic [PIX_W-1:0] mid_q [2];
  logic [PIX_W-1:0] lo_max, md_med, hi_min, median;

  // columns are stored sorted, raw middle pixels kept for pass-through
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= sort3(top_i, mid_i, bot_i);
      mid_q[0] <= mid_q[1];
      mid_q[1] <= mid_i;
    end
  end

  always_comb begin
    lo_max = max2(max2(win_q[0].lo, win_q[1].lo), win_q[2].lo);
    md_med = med3(win_q[0].md, win_q[1].md, win_q[2].md);
    hi_min = min2(min2(win_q[0].hi, win_q[1].hi), win_q[2].hi);
    median = med3(lo_max, md_med, hi_min);
    if (border_i) pix_o = use_new_i ? mid_q[1] : mid_q[0];
    else pix_o = median;
  end

endmodule

`default_nettype wire

>>> sv/median_filter_gray.sv
`default_nettype none

// channel   dir  handshake             payload
// s_axis    in   tvalid / tready       tdata = pixel_in, tuser = kind
// m_axis    out  tvalid / tready       tdata = pixel_out, tlast = last_of_frame
// cfg       in   cfg_valid / cfg_ready cfg_index = register, cfg_data = value
//
// one word per clock unless m_axis stalls; results pass stage 1, stage 2, output reg
// the rate is set by the line memory: one read and one write per clock
// reset clears the position counters and loads 320 x 240; line memory is not cleared
// a stalled output holds two more words in flight before s_axis_tready drops
// cfg_ready is always high; writes take effect on the next word

module median_filter_gray (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [mfg_pkg::PIX_W-1:0]     s_axis_tdata_i,   // [7:0] pixel_in
  input  logic                          s_axis_tuser_i,   // [0] kind
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mfg_pkg::PIX_W-1:0]     m_axis_tdata_o,   // [7:0] pixel_out
  output logic                          m_axis_tlast_o,   // last_of_frame
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mfg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mfg_pkg::DIM_W-1:0]     cfg_data_i
);
  import mfg_pkg::*;

  // stage 1: line memory read, stage 2: window, then the output register
  logic             s1_v_q, s2_v_q, out_v_q;
  item_ctl_t        s1_ctl_q, s2_ctl_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [COL_W-1:0] s1_col_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_last_q;

  logic             out_free, s2_go, s2_free, s1_go, s1_free, accept, take;
  logic [COL_W-1:0] take_col;
  item_ctl_t        take_ctl;
  lb_word_t         rd_word, wr_word;
  logic [PIX_W-1:0] win_pix;

  // words that give no result just leave stage 2
  assign out_free = !out_v_q || m_axis_tready_i;
  assign s2_go    = s2_v_q && (!s2_ctl_q.emit || out_free);
  assign s2_free  = !s2_v_q || s2_go;
  assign s1_go    = s1_v_q && s2_free;
  assign s1_free  = !s1_v_q || s1_go;

  assign s_axis_tready_o = s1_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // positions, frame sizes and per-word decisions
  mfg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .kind_i      (s_axis_tuser_i),
    .take_o      (take),
    .col_o       (take_col),
    .ctl_o       (take_ctl)
  );

  // each column pushes its rows down by one
  assign wr_word.mid = s1_pix_q;
  assign wr_word.top = rd_word.mid;

  mfg_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rd_en_i   (take),
    .rd_addr_i (take_col),
    .wr_en_i   (s1_go),
    .wr_addr_i (s1_col_q),
    .wr_data_i (wr_word),
    .rd_data_o (rd_word)
  );

  // drain ticks shift too, so the pending border pixels come out of the window
  mfg_window u_window (
    .clk_i     (clk_i),
    .shift_i   (s1_go),
    .top_i     (rd_word.top),
    .mid_i     (rd_word.mid),
    .bot_i     (s1_pix_q),
    .border_i  (s2_ctl_q.border),
    .use_new_i (s2_ctl_q.use_new),
    .pix_o     (win_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= take;
      if (s2_free) s2_v_q <= s1_go;
      if (out_free) out_v_q <= s2_go && s2_ctl_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_ctl_q <= take_ctl;
      s1_pix_q <= s_axis_tdata_i;
      s1_col_q <= take_col;
    end
    if (s1_go) s2_ctl_q <= s1_ctl_q;
    if (s2_go && s2_ctl_q.emit) begin
      out_pix_q  <= win_pix;
      out_last_q <= s2_ctl_q.last;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_pix_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

>>> sv/mfg_checker.sv
`default_nettype none

module mfg_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tready_o,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [mfg_pkg::PIX_W-1:0] m_axis_tdata_o,
  input logic                      m_axis_tlast_o
);

  // no result is offered while reset is applied
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("output valid during reset");

  // an empty or draining output register never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) |-> s_axis_tready_o)
    else $error("input stalled while output free");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)))
    else $error("stalled output word changed");

endmodule

bind median_filter_gray mfg_checker u_mfg_checker (.*);

`default_nettype wire
